[src/lpg_pkg.sv]
// shared types and constants of the line pixel generator
package lpg_pkg;

  // default panel size
  localparam int unsigned PANEL_WIDTH_DEF  = 240;
  localparam int unsigned PANEL_HEIGHT_DEF = 320;

  // field widths
  localparam int unsigned COORD_W = 11;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned ERR_W   = 13;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned ROT_W   = 2;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_ROTATION = 1'b0;  // register index, paddr[2]

  // item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_NEXT  = 1'b1;

  // rotation codes
  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  // rasterizer state of the line in progress
  typedef struct packed {
    logic                     active;
    logic signed [POS_W-1:0]  major_pos;
    logic signed [POS_W-1:0]  minor_pos;
    logic signed [POS_W-1:0]  major_end;
    logic [POS_W-1:0]         delta_major;
    logic [POS_W-1:0]         delta_minor;
    logic signed [ERR_W-1:0]  error_term;
    logic                     step_down;
    logic                     swapped;
    logic [COLOR_W-1:0]       color;
  } line_t;

  // one emitted pixel
  typedef struct packed {
    logic signed [POS_W-1:0] panel_x;
    logic signed [POS_W-1:0] panel_y;
    logic [COLOR_W-1:0]      pixel_color;
    logic                    last;
  } pixel_t;

endpackage

[src/lpg_channels.sv]
// handshake channels for line requests and emitted pixels
interface lpg_in_if;
  import lpg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [COLOR_W-1:0]        pen_color;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, pen_color,
                  input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, pen_color,
                  output ready);
endinterface

interface lpg_out_if;
  import lpg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] panel_x;
  logic signed [POS_W-1:0] panel_y;
  logic [COLOR_W-1:0]      pixel_color;
  logic                    last;

  modport source (output valid, panel_x, panel_y, pixel_color, last, input ready);
  modport sink   (input valid, panel_x, panel_y, pixel_color, last, output ready);
endinterface

[src/lpg_cfg.sv]
// apb register file holding the rotation setting
module lpg_cfg
  import lpg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [ROT_W-1:0]   rotation_o
);

  logic [ROT_W-1:0] rotation_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ROTATION);

  // rotation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rotation_q <= ROT_0;
    end else if (wr_en) begin
      rotation_q <= pwdata[ROT_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ROTATION) begin
      prdata = PDATA_W'(rotation_q);
    end
  end

  assign rotation_o = rotation_q;

endmodule

[src/lpg_setup.sv]
// line setup: axis swap, endpoint ordering and initial error term
module lpg_setup
  import lpg_pkg::*;
(
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic signed [COORD_W-1:0] end_x_i,
  input  logic signed [COORD_W-1:0] end_y_i,
  input  logic [COLOR_W-1:0]        pen_color_i,
  output line_t                     line_o
);

  logic signed [POS_W-1:0] ax, ay, bx, by;
  logic signed [POS_W-1:0] dx, dy;
  logic [POS_W-1:0]        adx, ady;
  logic                    steep;
  logic signed [POS_W-1:0] ma, na, mb, nb;   // major/minor of both endpoints
  logic signed [POS_W-1:0] maj0, min0, maj1, min1;
  logic signed [POS_W-1:0] dn;
  logic [POS_W-1:0]        dmaj;

  always_comb begin
    ax = POS_W'(start_x_i);
    ay = POS_W'(start_y_i);
    bx = POS_W'(end_x_i);
    by = POS_W'(end_y_i);

    // absolute deltas decide the major axis
    dx  = bx - ax;
    dy  = by - ay;
    adx = dx[POS_W-1] ? POS_W'(-dx) : dx;
    ady = dy[POS_W-1] ? POS_W'(-dy) : dy;
    steep = ady > adx;

    ma = steep ? ay : ax;
    na = steep ? ax : ay;
    mb = steep ? by : bx;
    nb = steep ? bx : by;

    // order endpoints so the major coordinate increases
    if (ma > mb) begin
      maj0 = mb; min0 = nb; maj1 = ma; min1 = na;
    end else begin
      maj0 = ma; min0 = na; maj1 = mb; min1 = nb;
    end

    dmaj = maj1 - maj0;
    dn   = min1 - min0;

    line_o.active      = 1'b1;
    line_o.major_pos   = maj0;
    line_o.minor_pos   = min0;
    line_o.major_end   = maj1;
    line_o.delta_major = dmaj;
    line_o.delta_minor = dn[POS_W-1] ? POS_W'(-dn) : dn;
    line_o.error_term  = ERR_W'(dmaj >> 1);
    line_o.step_down   = !(min0 < min1);
    line_o.swapped     = steep;
    line_o.color       = pen_color_i;
  end

endmodule

[src/lpg_step.sv]
// one rasterizer step: rotate the current pixel and advance the error term and position
module lpg_step
  import lpg_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  line_t            line_i,
  input  logic [ROT_W-1:0] rotation_i,
  output pixel_t           pixel_o,
  output line_t            line_o
);

  localparam logic signed [ERR_W-1:0] WIDTH_M1  = ERR_W'(PANEL_WIDTH - 1);
  localparam logic signed [ERR_W-1:0] HEIGHT_M1 = ERR_W'(PANEL_HEIGHT - 1);

  logic signed [ERR_W-1:0] lx, ly, px, py;
  logic signed [ERR_W-1:0] err_dec;
  logic                    fin;

  // rotation mapping of the current pixel
  always_comb begin
    lx  = ERR_W'(line_i.swapped ? line_i.minor_pos : line_i.major_pos);
    ly  = ERR_W'(line_i.swapped ? line_i.major_pos : line_i.minor_pos);
    fin = (line_i.major_pos == line_i.major_end);
    case (rotation_i)
      ROT_90: begin
        px = WIDTH_M1 - ly;
        py = lx;
      end
      ROT_180: begin
        px = WIDTH_M1 - lx;
        py = HEIGHT_M1 - ly;
      end
      ROT_270: begin
        px = ly;
        py = HEIGHT_M1 - lx;
      end
      default: begin
        px = lx;
        py = ly;
      end
    endcase
    pixel_o.panel_x     = px[POS_W-1:0];
    pixel_o.panel_y     = py[POS_W-1:0];
    pixel_o.pixel_color = line_i.color;
    pixel_o.last        = fin;
  end

  // error term and position update
  always_comb begin
    line_o  = line_i;
    err_dec = line_i.error_term - ERR_W'(line_i.delta_minor);
    line_o.error_term = err_dec;
    if (err_dec[ERR_W-1]) begin
      line_o.minor_pos  = line_i.step_down ? line_i.minor_pos - POS_W'(1)
                                           : line_i.minor_pos + POS_W'(1);
      line_o.error_term = err_dec + ERR_W'(line_i.delta_major);
    end
    if (fin) begin
      line_o.active = 1'b0;
    end else begin
      line_o.major_pos = line_i.major_pos + POS_W'(1);
    end
  end

endmodule

[src/line_pixel_generator.sv]
// line pixel generator top level: bresenham rasterizer with rotation mapping
// a next transaction's pixel is registered and appears on the output in the cycle after acceptance
// throughput: one input transaction per cycle while the output is not stalled, set by the single add/compare error step
// start transactions load the line and give no pixel; next transactions while idle give none
// the output register frees in the same cycle it is taken, so input stays open
// reset (rst_ni low, asynchronous) leaves the line idle and rotation at zero
module line_pixel_generator
  import lpg_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lpg_in_if.sink             in_ch,
  lpg_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [ROT_W-1:0] rotation;
  line_t            line_q, line_d;
  line_t            setup_line, step_line;
  pixel_t           step_pixel;
  pixel_t           pix_q, pix_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, emit;

  lpg_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .rotation_o (rotation)
  );

  lpg_setup u_setup (
    .start_x_i   (in_ch.start_x),
    .start_y_i   (in_ch.start_y),
    .end_x_i     (in_ch.end_x),
    .end_y_i     (in_ch.end_y),
    .pen_color_i (in_ch.pen_color),
    .line_o      (setup_line)
  );

  lpg_step #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_step (
    .line_i     (line_q),
    .rotation_i (rotation),
    .pixel_o    (step_pixel),
    .line_o     (step_line)
  );

  // handshake
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign emit        = accept && (in_ch.mode == MODE_NEXT) && line_q.active;

  // next line state and output register
  always_comb begin
    line_d      = line_q;
    pix_d       = pix_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    if (accept) begin
      if (in_ch.mode == MODE_START) begin
        line_d = setup_line;
      end else if (line_q.active) begin
        line_d      = step_line;
        pix_d       = step_pixel;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  // pixel payload register
  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.panel_x     = pix_q.panel_x;
  assign out_ch.panel_y     = pix_q.panel_y;
  assign out_ch.pixel_color = pix_q.pixel_color;
  assign out_ch.last        = pix_q.last;

  // a transaction that gives no pixel leaves the output empty
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !emit |=> !out_ch.valid)
    else $error("pixel shown for a transaction that gives none");

  // an emitted pixel always reaches the output
  a_emit_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_ch.valid)
    else $error("emitted pixel lost");

  // the final pixel ends the line
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && step_pixel.last |=> !line_q.active)
    else $error("line still active after its last pixel");

  // error term never rests negative and major position stays in range
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q.active |-> !line_q.error_term[ERR_W-1] && (line_q.major_pos <= line_q.major_end))
    else $error("line state out of range");

endmodule
